### sv/mbm_pkg.sv
// Shared types, codes, CRC and register address helpers for the Modbus meter read master.
package mbm_pkg;

    // Stream and configuration port widths
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 48;
    localparam int M_TDATA_PAD = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // Input item kinds (s_tuser)
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Result kinds (m_tuser)
    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    // Outcome status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_NO_RESP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_METER_KIND = 1'b1;

    // Modbus constants
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT   = 8'h04;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [2:0]  Q_ENERGY          = 3'd5;
    localparam logic [8:0]  FIXED_FRAME_LEN   = 9'd10;
    localparam logic [8:0]  COUNTED_OVERHEAD  = 9'd5;

    // Receive frame tracking state
    typedef struct packed {
        logic [15:0] crc;
        logic [8:0]  pos;
        logic [8:0]  flen;
        logic [31:0] data;
        logic [7:0]  first_crc;
    } frame_t;

    // Per-byte check outcome
    typedef struct packed {
        logic       done;
        logic [1:0] status;
    } chk_res_t;

    // One byte through CRC-16/MODBUS, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Register address for a quantity code
    function automatic logic [15:0] reg_address(input logic kind, input logic [2:0] q);
        logic [15:0] a;
        a = 16'h0000;
        if (kind) begin
            case (q)
                3'd0:    a = 16'h0A00;
                3'd1:    a = 16'h0B00;
                3'd2:    a = 16'h0800;
                3'd3:    a = 16'h0900;
                3'd4:    a = 16'h0D00;
                3'd5:    a = 16'h0100;
                3'd6:    a = 16'h0C00;
                default: a = 16'h0000;
            endcase
        end else begin
            case (q)
                3'd0:    a = 16'h0000;
                3'd1:    a = 16'h0006;
                3'd2:    a = 16'h000C;
                3'd3:    a = 16'h0018;
                3'd4:    a = 16'h0046;
                3'd5:    a = 16'h0156;
                3'd6:    a = 16'h001E;
                default: a = 16'h0000;
            endcase
        end
        return a;
    endfunction

endpackage

### sv/mbm_frame_chk.sv
// Per-byte reply frame check: address/function match, CRC, data capture, end of frame.
module mbm_frame_chk (
    input  logic            k1,
    input  logic [7:0]      dev_addr,
    input  logic [7:0]      func,
    input  mbm_pkg::frame_t frame_in,
    input  logic [7:0]      rx_byte,
    output mbm_pkg::frame_t frame_out,
    output mbm_pkg::chk_res_t res
);
    import mbm_pkg::*;

    logic [8:0]  pos;
    logic [8:0]  flen_n;
    logic [8:0]  flen_m2;
    logic [8:0]  pos_n;
    logic        flen_ok;
    logic        in_crc;
    logic        bad;
    logic        good;
    logic [15:0] crc_n;
    logic [31:0] data_n;
    logic [7:0]  first_n;

    always_comb begin
        pos     = frame_in.pos;
        bad     = ((pos == 9'd0) && (rx_byte != dev_addr)) ||
                  ((pos == 9'd1) && (rx_byte != func));
        // byte-counted frame: length known once the count byte arrives
        flen_n  = (!k1 && pos == 9'd2) ? ({1'b0, rx_byte} + COUNTED_OVERHEAD) : frame_in.flen;
        flen_ok = (flen_n >= COUNTED_OVERHEAD);
        flen_m2 = flen_n - 9'd2;
        in_crc  = (pos < 9'd3) || (flen_ok && (pos < flen_m2));
        crc_n   = in_crc ? crc16_byte(frame_in.crc, rx_byte) : frame_in.crc;

        data_n = frame_in.data;
        if (k1) begin
            case (pos)
                9'd4:    data_n[7:0]   = data_n[7:0]   | rx_byte;
                9'd5:    data_n[15:8]  = data_n[15:8]  | rx_byte;
                9'd6:    data_n[23:16] = data_n[23:16] | rx_byte;
                9'd7:    data_n[31:24] = data_n[31:24] | rx_byte;
                default: data_n = frame_in.data;
            endcase
        end else begin
            case (pos)
                9'd3:    data_n[31:24] = data_n[31:24] | rx_byte;
                9'd4:    data_n[23:16] = data_n[23:16] | rx_byte;
                9'd5:    data_n[15:8]  = data_n[15:8]  | rx_byte;
                9'd6:    data_n[7:0]   = data_n[7:0]   | rx_byte;
                default: data_n = frame_in.data;
            endcase
        end

        first_n = (flen_ok && pos == flen_m2) ? rx_byte : frame_in.first_crc;
        pos_n   = pos + 9'd1;

        // kind 1 sends the CRC high byte first
        good = k1 ? ((first_n == crc_n[15:8]) && (rx_byte == crc_n[7:0]))
                  : ((first_n == crc_n[7:0])  && (rx_byte == crc_n[15:8]));

        frame_out.crc       = crc_n;
        frame_out.pos       = pos_n;
        frame_out.flen      = flen_n;
        frame_out.data      = data_n;
        frame_out.first_crc = first_n;

        if (bad) begin
            res.done   = 1'b1;
            res.status = ST_NO_RESP;
        end else if (flen_ok && pos_n == flen_n) begin
            res.done   = 1'b1;
            res.status = good ? ST_OK : ST_CRC_ERR;
        end else begin
            res.done   = 1'b0;
            res.status = ST_OK;
        end
    end

endmodule

### sv/modbus_meter_read_master.sv
// Start: request byte 0 appears the cycle after the start transaction, then one byte a cycle
// while m_tready allows; no new item is accepted until all eight request bytes are issued.
// Received byte: one per cycle unless stalled; outcome valid the cycle after the last byte.
// Timeout: missing bytes are fed as zeros through the CRC byte unit, one byte a cycle while
// m_tready allows; no further item is accepted until the frame closes.
// Reset (aresetn low, synchronous): idle, no output valid, config registers zero.
module modbus_meter_read_master (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbm_pkg::S_TDATA_W-1:0]  s_tdata,   // quantity[2:0], rx_byte[10:3], zeros
    input  logic [mbm_pkg::S_TUSER_W-1:0]  s_tuser,   // opcode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mbm_pkg::M_TDATA_W-1:0]  m_tdata,   // tx_byte[7:0], status[9:8],
                                                      // reading_bits[41:10], zeros
    output logic                           m_tuser,   // result_kind
    output logic                           m_tlast,   // last
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mbm_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT0 = 2'd1;
    localparam logic [1:0] PH_WAIT1 = 2'd2;

    localparam logic [2:0] TX_CRC_FIRST = 3'd6;
    localparam logic [2:0] TX_LAST      = 3'd7;

    logic [7:0]  dev_addr_reg;
    logic        meter_kind_reg;
    logic [1:0]  phase_reg,   phase_next;
    logic [7:0]  func_reg,    func_next;
    frame_t      frame_reg,   frame_next;
    logic        flush_reg,   flush_next;
    logic        tx_busy_reg, tx_busy_next;
    logic [2:0]  tx_cnt_reg,  tx_cnt_next;
    logic [15:0] tx_crc_reg,  tx_crc_next;
    logic        tx_kind_reg, tx_kind_next;
    logic [15:0] tx_raddr_reg, tx_raddr_next;
    logic [7:0]  tx_b4_reg,   tx_b4_next;
    logic [7:0]  tx_b5_reg,   tx_b5_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic                 m_tuser_reg,  m_tuser_next;
    logic                 m_tlast_reg,  m_tlast_next;

    logic [1:0]  opcode;
    logic [2:0]  quantity;
    logic [7:0]  rx_byte;
    logic        out_free;
    logic        s_acc;
    logic        start_acc;
    logic        rx_acc;
    logic        to_acc;
    logic        flush_step;
    logic        chk_step;
    logic        tx_step;
    logic [7:0]  chk_byte;
    logic [7:0]  tx_byte;
    logic        is_energy;
    frame_t      chk_frame;
    chk_res_t    chk_res;

    assign opcode   = s_tuser;
    assign quantity = s_tdata[2:0];
    assign rx_byte  = s_tdata[10:3];

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = out_free && !tx_busy_reg && !flush_reg;
    assign s_acc      = s_tvalid && s_tready;
    assign start_acc  = s_acc && (opcode == OP_START);
    assign rx_acc     = s_acc && (opcode == OP_RX_BYTE) && (phase_reg != PH_IDLE);
    assign to_acc     = s_acc && (opcode == OP_TIMEOUT) && (phase_reg != PH_IDLE);
    assign flush_step = flush_reg && out_free;
    assign chk_step   = rx_acc || flush_step;
    assign tx_step    = tx_busy_reg && out_free;
    // missing bytes after a timeout count as zero
    assign chk_byte   = flush_reg ? 8'h00 : rx_byte;
    assign is_energy  = (quantity == Q_ENERGY);

    assign cfg_ready = 1'b1;

    mbm_frame_chk u_frame_chk (
        .k1        (phase_reg == PH_WAIT1),
        .dev_addr  (dev_addr_reg),
        .func      (func_reg),
        .frame_in  (frame_reg),
        .rx_byte   (chk_byte),
        .frame_out (chk_frame),
        .res       (chk_res)
    );

    always_comb begin
        case (tx_cnt_reg)
            3'd1:         tx_byte = func_reg;
            3'd2:         tx_byte = tx_raddr_reg[15:8];
            3'd3:         tx_byte = tx_raddr_reg[7:0];
            3'd4:         tx_byte = tx_b4_reg;
            3'd5:         tx_byte = tx_b5_reg;
            TX_CRC_FIRST: tx_byte = tx_kind_reg ? tx_crc_reg[15:8] : tx_crc_reg[7:0];
            TX_LAST:      tx_byte = tx_kind_reg ? tx_crc_reg[7:0]  : tx_crc_reg[15:8];
            default:      tx_byte = dev_addr_reg;
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        func_next     = func_reg;
        frame_next    = frame_reg;
        flush_next    = flush_reg;
        tx_busy_next  = tx_busy_reg;
        tx_cnt_next   = tx_cnt_reg;
        tx_crc_next   = tx_crc_reg;
        tx_kind_next  = tx_kind_reg;
        tx_raddr_next = tx_raddr_reg;
        tx_b4_next    = tx_b4_reg;
        tx_b5_next    = tx_b5_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        if (start_acc) begin
            // latch the request, byte 0 (address) goes out right away
            func_next     = (meter_kind_reg && !is_energy) ? FUNC_READ_HOLDING
                                                           : FUNC_READ_INPUT;
            tx_kind_next  = meter_kind_reg;
            tx_raddr_next = reg_address(meter_kind_reg, quantity);
            tx_b4_next    = (meter_kind_reg && is_energy) ? 8'h01 : 8'h00;
            tx_b5_next    = meter_kind_reg ? 8'h01 : 8'h02;
            tx_crc_next   = crc16_byte(CRC_INIT, dev_addr_reg);
            tx_cnt_next   = 3'd1;
            tx_busy_next  = 1'b1;
            phase_next    = meter_kind_reg ? PH_WAIT1 : PH_WAIT0;
            flush_next    = 1'b0;
            frame_next.crc       = CRC_INIT;
            frame_next.pos       = 9'd0;
            frame_next.flen      = meter_kind_reg ? FIXED_FRAME_LEN : 9'd0;
            frame_next.data      = 32'd0;
            frame_next.first_crc = 8'h00;
        end else if (tx_step) begin
            if (tx_cnt_reg < TX_CRC_FIRST) begin
                tx_crc_next = crc16_byte(tx_crc_reg, tx_byte);
            end
            tx_cnt_next = tx_cnt_reg + 3'd1;
            if (tx_cnt_reg == TX_LAST) begin
                tx_busy_next = 1'b0;
            end
        end

        if (to_acc) begin
            flush_next = 1'b1;
        end

        if (chk_step) begin
            frame_next = chk_frame;
            if (chk_res.done) begin
                phase_next = PH_IDLE;
                flush_next = 1'b0;
            end
        end

        if (out_free) begin
            if (start_acc) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = KIND_TX;
                m_tlast_next  = 1'b0;
                m_tdata_next  = {{M_TDATA_PAD{1'b0}}, 32'd0, ST_OK, dev_addr_reg};
            end else if (tx_step) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = KIND_TX;
                m_tlast_next  = (tx_cnt_reg == TX_LAST);
                m_tdata_next  = {{M_TDATA_PAD{1'b0}}, 32'd0, ST_OK, tx_byte};
            end else if (chk_step && chk_res.done) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = KIND_OUTCOME;
                m_tlast_next  = 1'b1;
                m_tdata_next  = {{M_TDATA_PAD{1'b0}},
                                 (chk_res.status == ST_OK) ? chk_frame.data : 32'd0,
                                 chk_res.status, 8'h00};
            end else begin
                m_tvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg   <= 8'h00;
            meter_kind_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            flush_reg      <= 1'b0;
            tx_busy_reg    <= 1'b0;
            tx_cnt_reg     <= 3'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEV_ADDR:   dev_addr_reg   <= cfg_wdata;
                    REG_METER_KIND: meter_kind_reg <= cfg_wdata[0];
                    default:        dev_addr_reg   <= dev_addr_reg;
                endcase
            end
            phase_reg    <= phase_next;
            flush_reg    <= flush_next;
            tx_busy_reg  <= tx_busy_next;
            tx_cnt_reg   <= tx_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        frame_reg    <= frame_next;
        tx_crc_reg   <= tx_crc_next;
        tx_kind_reg  <= tx_kind_next;
        tx_raddr_reg <= tx_raddr_next;
        tx_b4_reg    <= tx_b4_next;
        tx_b5_reg    <= tx_b5_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### sv/mbm_checker.sv
// Port-level assertions for the Modbus meter read master, bound to the top level.
module mbm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mbm_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mbm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import mbm_pkg::*;

    // start: address byte is loaded at once and the request holds off new input
    a_start_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_START) |=>
            (m_tvalid && m_tuser == KIND_TX && !m_tlast && !s_tready))
        else $error("start transaction did not begin a request");

    // outcome closes the run, carries no tx byte, reading only when ok
    a_outcome_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_OUTCOME) |->
            (m_tlast && m_tdata[7:0] == 8'h00 && m_tdata[9:8] != 2'd3 &&
             (m_tdata[9:8] == ST_OK || m_tdata[41:10] == 32'd0)))
        else $error("malformed outcome transaction");

    // request bytes carry zero status, zero reading and zero padding
    a_tx_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_TX) |-> (m_tdata[M_TDATA_W-1:8] == '0))
        else $error("request byte transaction has nonzero upper fields");

    // a request byte that is not last is followed by another request byte once taken
    a_tx_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == KIND_TX && !m_tlast) |=>
            (m_tvalid && m_tuser == KIND_TX))
        else $error("request byte run broken");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind modbus_meter_read_master mbm_checker u_mbm_checker (.*);

### tb/modbus_meter_read_master_tb.sv
// Self-checking testbench for the Modbus meter read master: request bytes and reading outcomes.
module modbus_meter_read_master_tb;
    import mbm_pkg::*;

    localparam logic [1:0] OP_RESERVED   = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         FILL_GUARD    = 300;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_WAIT_COUNTED,
        LINK_WAIT_FIXED
    } link_phase_t;

    typedef enum int {
        RPL_GOOD,
        RPL_BAD_CRC,
        RPL_BAD_ADDR,
        RPL_BAD_FUNC,
        RPL_CUT_TIMEOUT,
        RPL_ABANDON
    } reply_shape_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic [1:0]  status;
        logic [31:0] bits;
        logic        last;
    } meter_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = OP_START;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DEV_ADDR;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the block: configuration and receive-frame tracking
    logic [7:0]  cur_dev_addr   = 8'h00;
    logic        cur_fixed_kind = 1'b0;
    link_phase_t link_phase     = LINK_IDLE;
    logic [7:0]  req_func       = 8'h00;
    logic [15:0] rx_crc         = CRC_INIT;
    logic [8:0]  rx_count       = '0;
    logic [8:0]  frame_len      = '0;
    logic [31:0] rx_word        = '0;
    logic [7:0]  rx_first_crc   = 8'h00;
    meter_out_t  due_outputs[$];

    // Stimulus-side view of what the meter should answer
    logic [7:0] set_addr  = 8'h00;
    logic       set_kind  = 1'b0;
    logic [7:0] gen_func  = FUNC_READ_INPUT;
    logic       gen_fixed = 1'b0;

    int fail_count     = 0;
    int items_sent     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    modbus_meter_read_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] quantity_register(input logic fixed, input logic [2:0] q);
        logic [15:0] a;
        case ({fixed, q})
            4'b0_001: a = 16'h0006;
            4'b0_010: a = 16'h000C;
            4'b0_011: a = 16'h0018;
            4'b0_100: a = 16'h0046;
            4'b0_101: a = 16'h0156;
            4'b0_110: a = 16'h001E;
            4'b1_000: a = 16'h0A00;
            4'b1_001: a = 16'h0B00;
            4'b1_010: a = 16'h0800;
            4'b1_011: a = 16'h0900;
            4'b1_100: a = 16'h0D00;
            4'b1_101: a = 16'h0100;
            4'b1_110: a = 16'h0C00;
            default:  a = 16'h0000;
        endcase
        return a;
    endfunction

    function automatic void issue_request(input logic [2:0] q);
        logic [7:0]  req [8];
        logic [15:0] reg_addr;
        logic [15:0] crc;
        reg_addr = quantity_register(cur_fixed_kind, q);
        if (cur_fixed_kind) begin
            req_func = (q == Q_ENERGY) ? FUNC_READ_INPUT : FUNC_READ_HOLDING;
            req[4]   = (q == Q_ENERGY) ? 8'h01 : 8'h00;
            req[5]   = 8'h01;
        end else begin
            req_func = FUNC_READ_INPUT;
            req[4]   = 8'h00;
            req[5]   = 8'h02;
        end
        req[0] = cur_dev_addr;
        req[1] = req_func;
        req[2] = reg_addr[15:8];
        req[3] = reg_addr[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++)
            crc = modbus_crc_step(crc, req[i]);
        // fixed-frame meters take the CRC high byte first
        if (cur_fixed_kind) begin
            req[6] = crc[15:8];
            req[7] = crc[7:0];
        end else begin
            req[6] = crc[7:0];
            req[7] = crc[15:8];
        end
        link_phase   = cur_fixed_kind ? LINK_WAIT_FIXED : LINK_WAIT_COUNTED;
        rx_crc       = CRC_INIT;
        rx_count     = '0;
        frame_len    = cur_fixed_kind ? FIXED_FRAME_LEN : 9'd0;
        rx_word      = '0;
        rx_first_crc = 8'h00;
        for (int i = 0; i < 8; i++)
            due_outputs.push_back('{KIND_TX, req[i], ST_OK, 32'h0, (i == 7)});
    endfunction

    // Returns -1 while the frame goes on, else the outcome status
    function automatic int absorb_reply_byte(input logic [7:0] b);
        logic       fixed;
        logic       len_known;
        logic       in_crc;
        logic       good;
        logic [8:0] pos;
        fixed = (link_phase == LINK_WAIT_FIXED);
        pos   = rx_count;
        if (pos == 9'd0 && b != cur_dev_addr)
            return ST_NO_RESP;
        if (pos == 9'd1 && b != req_func)
            return ST_NO_RESP;
        if (!fixed && pos == 9'd2)
            frame_len = {1'b0, b} + COUNTED_OVERHEAD;
        len_known = (frame_len != 9'd0);
        in_crc = (pos < 9'd3) || (len_known && pos < frame_len - 9'd2);
        if (in_crc)
            rx_crc = modbus_crc_step(rx_crc, b);
        // reading window is fixed by position, even over CRC bytes
        if (!fixed && pos >= 9'd3 && pos <= 9'd6)
            rx_word = rx_word | ({24'd0, b} << (8 * (6 - pos)));
        if (fixed && pos >= 9'd4 && pos <= 9'd7)
            rx_word = rx_word | ({24'd0, b} << (8 * (pos - 4)));
        if (len_known && pos == frame_len - 9'd2)
            rx_first_crc = b;
        pos      = pos + 9'd1;
        rx_count = pos;
        if (len_known && pos == frame_len) begin
            if (fixed)
                good = (rx_first_crc == rx_crc[15:8]) && (b == rx_crc[7:0]);
            else
                good = (rx_first_crc == rx_crc[7:0]) && (b == rx_crc[15:8]);
            return good ? ST_OK : ST_CRC_ERR;
        end
        return -1;
    endfunction

    function automatic void master_step(input logic [1:0] op, input logic [2:0] q,
                                        input logic [7:0] rx);
        int st;
        int guard;
        st = -1;
        if (op == OP_START) begin
            issue_request(q);
            return;
        end
        if (link_phase == LINK_IDLE)
            return;
        if (op == OP_RX_BYTE) begin
            st = absorb_reply_byte(rx);
        end else if (op == OP_TIMEOUT) begin
            // missing bytes count as zero until the frame closes
            for (guard = 0; guard < FILL_GUARD && st < 0; guard++)
                st = absorb_reply_byte(8'h00);
            if (st < 0)
                st = ST_NO_RESP;
        end else begin
            return;
        end
        if (st < 0)
            return;
        due_outputs.push_back('{KIND_OUTCOME, 8'h00, st[1:0],
                                (st == ST_OK) ? rx_word : 32'h0, 1'b1});
        link_phase = LINK_IDLE;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Outputs are checked before the same edge's input transaction is predicted
    always @(posedge aclk) begin : bus_monitor
        meter_out_t got;
        meter_out_t want;
        if (!aresetn) begin
            cur_dev_addr   = 8'h00;
            cur_fixed_kind = 1'b0;
            link_phase     = LINK_IDLE;
            req_func       = 8'h00;
            rx_crc         = CRC_INIT;
            rx_count       = '0;
            frame_len      = '0;
            rx_word        = '0;
            rx_first_crc   = 8'h00;
            due_outputs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[41:10], m_tlast};
                if (due_outputs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = due_outputs.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("tx_byte", want.tx, got.tx);
                    check_field("status", want.status, got.status);
                    check_field("reading_bits", want.bits, got.bits);
                    check_field("last", want.last, got.last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DEV_ADDR)
                    cur_dev_addr = cfg_wdata;
                else if (cfg_index == REG_METER_KIND)
                    cur_fixed_kind = cfg_wdata[0];
            end
            if (s_tvalid && s_tready)
                master_step(s_tuser, s_tdata[2:0], s_tdata[10:3]);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [2:0] q, input logic [7:0] rx);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, rx, q};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_start(input logic [2:0] q);
        gen_fixed = set_kind;
        if (set_kind && q != Q_ENERGY)
            gen_func = FUNC_READ_HOLDING;
        else
            gen_func = FUNC_READ_INPUT;
        send_item(OP_START, q, 8'($urandom_range(255)));
    endtask

    // cut < 0 picks a random truncation point for the cut shapes
    task automatic send_reply(input reply_shape_t shape, input int count, input int cut);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          n;
        if (shape == RPL_BAD_ADDR)
            frame.push_back(set_addr ^ 8'($urandom_range(1, 255)));
        else
            frame.push_back(set_addr);
        if (shape == RPL_BAD_FUNC)
            frame.push_back(gen_func ^ (8'h01 << $urandom_range(7)));
        else
            frame.push_back(gen_func);
        if (gen_fixed) begin
            repeat (6) frame.push_back(8'($urandom_range(255)));
        end else begin
            frame.push_back(8'(count));
            repeat (count) frame.push_back(8'($urandom_range(255)));
        end
        crc = CRC_INIT;
        foreach (frame[i])
            crc = modbus_crc_step(crc, frame[i]);
        if (shape == RPL_BAD_CRC)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        if (gen_fixed) begin
            frame.push_back(crc[15:8]);
            frame.push_back(crc[7:0]);
        end else begin
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
        end
        case (shape)
            RPL_BAD_ADDR:                n = 1;
            RPL_BAD_FUNC:                n = 2;
            RPL_CUT_TIMEOUT, RPL_ABANDON: n = (cut >= 0) ? cut : $urandom_range(frame.size() - 1);
            default:                     n = frame.size();
        endcase
        for (int i = 0; i < n; i++)
            send_item(OP_RX_BYTE, 3'($urandom_range(7)), frame[i]);
        if (shape == RPL_CUT_TIMEOUT)
            send_item(OP_TIMEOUT, 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] addr, input logic kind);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DEV_ADDR;
        cfg_wdata <= addr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_METER_KIND;
        cfg_wdata <= {7'd0, kind};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_addr = addr;
        set_kind = kind;
    endtask

    // Bytes, timeouts and reserved items with no request pending must produce nothing
    task automatic test_idle_traffic();
        write_config(8'h00, 1'b0);
        send_item(OP_RX_BYTE, 3'd7, 8'hFF);
        send_item(OP_TIMEOUT, 3'd0, 8'h00);
        send_item(OP_RESERVED, 3'd7, 8'hFF);
        settle();
    endtask

    task automatic test_counted_frames();
        // unmapped quantity, then a zero-count reply whose reading spans the CRC
        send_start(3'd7);
        send_reply(RPL_GOOD, 0, -1);
        // second start drops the first without an outcome
        send_start(3'd0);
        send_start(3'd1);
        send_reply(RPL_BAD_FUNC, 4, -1);
        settle();
    endtask

    task automatic test_fixed_frames();
        write_config(8'hFF, 1'b1);
        send_start(Q_ENERGY);
        send_reply(RPL_CUT_TIMEOUT, 0, 2);
        send_start(3'd6);
        send_reply(RPL_BAD_ADDR, 0, -1);
        send_start(3'd3);
        send_reply(RPL_ABANDON, 0, 4);
        settle();
        // kind switch mid-frame: the pending reply keeps its fixed framing
        write_config(8'hFF, 1'b0);
        send_item(OP_TIMEOUT, 3'd0, 8'h00);
        settle();
    endtask

    task automatic test_random_traffic(input int target);
        int           first;
        int           roll;
        int           count;
        int           cut;
        logic [7:0]   addr;
        reply_shape_t shape;
        first = items_sent;
        while (items_sent - first < target) begin
            if ($urandom_range(5) == 0) begin
                settle();
                case ($urandom_range(2))
                    0:       addr = 8'h00;
                    1:       addr = 8'hFF;
                    default: addr = 8'($urandom_range(255));
                endcase
                write_config(addr, 1'($urandom_range(1)));
            end
            send_start(3'($urandom_range(7)));
            roll  = $urandom_range(99);
            count = 4;
            cut   = -1;
            if (roll < 60)
                shape = RPL_GOOD;
            else if (roll < 70)
                shape = RPL_BAD_CRC;
            else if (roll < 76)
                shape = RPL_BAD_ADDR;
            else if (roll < 82)
                shape = RPL_BAD_FUNC;
            else if (roll < 94)
                shape = RPL_CUT_TIMEOUT;
            else
                shape = RPL_ABANDON;
            if (!gen_fixed) begin
                if ($urandom_range(3) == 0)
                    count = $urandom_range(8);
                // longest frame: let the block fill it with zeros
                if ($urandom_range(15) == 0) begin
                    count = 255;
                    shape = RPL_CUT_TIMEOUT;
                    cut   = $urandom_range(3, 9);
                end
            end
            send_reply(shape, count, cut);
            if ($urandom_range(7) == 0)
                send_item(2'($urandom_range(1, 3)), 3'($urandom_range(7)),
                          8'($urandom_range(255)));
        end
    endtask

    initial begin
        src_idle_pct   = 8;
        sink_stall_pct = 82;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_traffic();
        test_counted_frames();
        test_fixed_frames();
        test_random_traffic(80);
        src_idle_pct   = 82;
        sink_stall_pct = 8;
        test_random_traffic(80);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(80);
        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
